/* rtl/core/multi_channel_timed_relay_controller_assert.svh */
// Assertion macros for the timed relay controller.
// Depends on nothing; included by the top level, which carries the assertions.
`ifndef MULTI_CHANNEL_TIMED_RELAY_CONTROLLER_ASSERT_SVH
`define MULTI_CHANNEL_TIMED_RELAY_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define MCTRC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("relay controller check failed");
// Next-cycle implication, disabled in reset.
`define MCTRC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("relay controller check failed");
`else
`define MCTRC_ASSERT_IMP(label, clk, rst, ante, cons)
`define MCTRC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/mctrc_pkg.sv */
// Shared types, codes and helpers for the timed relay controller.
// Depends on nothing.
package mctrc_pkg;

   localparam int BITS_EACH  = 3;
   localparam int CTRL_WIDTH = 24;
   localparam int EXP_WIDTH  = 8;
   localparam int CFG_WIDTH  = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from the byte address
   localparam logic REG_ON_HOLD = 1'b0;
   localparam logic REG_PULSE   = 1'b1;

   localparam logic [CFG_WIDTH-1:0] ON_HOLD_RESET = 24'd60000;
   localparam logic [CFG_WIDTH-1:0] PULSE_RESET   = 24'd1000;

   localparam logic [BITS_EACH-1:0] UP_BIT   = 3'b001;
   localparam logic [BITS_EACH-1:0] STOP_BIT = 3'b010;
   localparam logic [BITS_EACH-1:0] DOWN_BIT = 3'b100;

   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_UP        = 3'd1,
      CMD_STOP      = 3'd2,
      CMD_DOWN      = 3'd3,
      CMD_STOP_DOWN = 3'd4,
      CMD_STOP_UP   = 3'd5,
      CMD_ALL       = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_ON    = 2'd1,
      MODE_PULSE = 2'd2
   } mode_type;

   typedef enum logic {
      FUNC_CMD  = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   // per-channel operation for one word
   typedef struct packed {
      logic                 tick;
      logic                 load;
      logic                 drive_on;
      logic [BITS_EACH-1:0] mask;
   } chan_op_type;

   // per-channel status after the word
   typedef struct packed {
      logic                 expired;
      logic [BITS_EACH-1:0] bits_next;
   } chan_stat_type;

   function automatic logic [BITS_EACH-1:0] cmd_mask(input logic [2:0] cmd);
      logic [BITS_EACH-1:0] m;
      m = '0;
      case (cmd)
         CMD_UP:        m = UP_BIT;
         CMD_STOP:      m = STOP_BIT;
         CMD_DOWN:      m = DOWN_BIT;
         CMD_STOP_DOWN: m = STOP_BIT | DOWN_BIT;
         CMD_STOP_UP:   m = STOP_BIT | UP_BIT;
         CMD_ALL:       m = UP_BIT | STOP_BIT | DOWN_BIT;
         default:       m = '0;
      endcase
      return m;
   endfunction

endpackage

/* rtl/core/multi_channel_timed_relay_controller.sv */
// Top level of the multi-channel timed relay controller.
// Depends on mctrc_pkg, mctrc_channel and the assertion macro header.
//
// Usage
//   req_*  : one word per item. tuser = func (0 command, 1 millisecond tick);
//            tdata = channel, command and drive mode. A command clears the
//            addressed channel, then drives the chosen up/stop/down bits on
//            or off; on and pulse modes start the channel timer from
//            on_hold_ms or pulse_ms (zero: no timer). A tick advances every
//            running timer and clears channels whose time has run out.
//   rsp_*  : one word per item: packed relay bits and the expired mask.
//   csr_*  : APB-style writes/reads, on_hold_ms at 0x0, pulse_ms at 0x4.
// Timing
//   Two register stages (input register, result register): a taken word
//   moves from the input register into the result register, raising
//   rsp_tvalid, once that is free or draining. One word is taken every cycle while
//   rsp_tready is high. All timers update in parallel in the channel slices.
// Reset clears relay bits, timers and both valid flags; registers return to
//   60000 ms and 1000 ms. When the receiver stalls the result register holds,
//   the input register fills once more, then req_tready drops.
`include "multi_channel_timed_relay_controller_assert.svh"
module multi_channel_timed_relay_controller #(
   parameter int CHANNELS   = 8,
   parameter int TIMER_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // channel[2:0], command[5:3],
                                                            // drive_mode[7:6]
   input  logic                                 req_tuser,  // func[0]
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,  // control_word[23:0],
                                                            // expired_mask[31:24]
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mctrc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mctrc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mctrc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   localparam int BE      = mctrc_pkg::BITS_EACH;
   localparam int CFG_W   = mctrc_pkg::CFG_WIDTH;
   localparam int RELAY_W = CHANNELS * BE;
   localparam int CTRL_W  = mctrc_pkg::CTRL_WIDTH;
   localparam int EXP_W   = mctrc_pkg::EXP_WIDTH;
   localparam int WIDE_R  = (RELAY_W > CTRL_W) ? RELAY_W : CTRL_W;
   localparam int WIDE_E  = (CHANNELS > EXP_W) ? CHANNELS : EXP_W;
   localparam int DUR_W   = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
   localparam logic [DUR_W-1:0] TIMER_MAX = DUR_W'({TIMER_BITS{1'b1}});

   // ---------------- configuration registers ----------------
   logic [CFG_W-1:0] on_hold_ff, pulse_ff;
   logic             csr_write;
   logic             csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         on_hold_ff <= mctrc_pkg::ON_HOLD_RESET;
         pulse_ff   <= mctrc_pkg::PULSE_RESET;
      end else if (csr_write) begin
         if (csr_index == mctrc_pkg::REG_ON_HOLD) begin
            on_hold_ff <= csr_pwdata[CFG_W-1:0];
         end else begin
            pulse_ff <= csr_pwdata[CFG_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_index == mctrc_pkg::REG_ON_HOLD) begin
         csr_prdata = mctrc_pkg::CSR_DATA_W'(on_hold_ff);
      end else begin
         csr_prdata = mctrc_pkg::CSR_DATA_W'(pulse_ff);
      end
   end

   // ---------------- input register ----------------
   logic       in_valid_ff;
   logic       in_func_ff;
   logic [2:0] in_channel_ff;
   logic [2:0] in_command_ff;
   logic [1:0] in_mode_ff;
   logic       advance;
   logic       req_take;

   // advance the input word when the result register is free or draining
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff    <= req_tuser;
         in_channel_ff <= req_tdata[2:0];
         in_command_ff <= req_tdata[5:3];
         in_mode_ff    <= req_tdata[7:6];
      end
   end

   // ---------------- decode one word ----------------
   logic                  fire;
   logic [BE-1:0]         mask;
   logic                  drive_on;
   logic [CFG_W-1:0]      dur_cfg;
   logic [DUR_W-1:0]      dur_wide;
   logic [TIMER_BITS-1:0] dur;
   logic                  cmd_ok;

   assign fire = in_valid_ff && advance;
   assign mask = mctrc_pkg::cmd_mask(in_command_ff);

   always_comb begin
      case (in_mode_ff)
         mctrc_pkg::MODE_ON: begin
            drive_on = 1'b1;
            dur_cfg  = on_hold_ff;
         end
         mctrc_pkg::MODE_PULSE: begin
            drive_on = 1'b1;
            dur_cfg  = pulse_ff;
         end
         default: begin
            // off and the unused mode code: bits cleared, no timer
            drive_on = 1'b0;
            dur_cfg  = '0;
         end
      endcase
   end

   // saturate the duration to the timer width
   assign dur_wide = DUR_W'(dur_cfg);
   assign dur      = (dur_wide > TIMER_MAX) ? TIMER_BITS'(TIMER_MAX)
                                            : TIMER_BITS'(dur_wide);

   assign cmd_ok = fire && (in_func_ff == mctrc_pkg::FUNC_CMD) && (mask != '0)
                   && (32'(in_channel_ff) < CHANNELS);

   // ---------------- channel slices ----------------
   logic [WIDE_R-1:0] relay_next;
   logic [WIDE_E-1:0] expired_next;

   generate
      if (WIDE_R > RELAY_W) begin : g_relay_pad
         assign relay_next[WIDE_R-1:RELAY_W] = '0;
      end
      if (WIDE_E > CHANNELS) begin : g_exp_pad
         assign expired_next[WIDE_E-1:CHANNELS] = '0;
      end
   endgenerate

   genvar c;
   generate
      for (c = 0; c < CHANNELS; c++) begin : g_chan
         mctrc_pkg::chan_op_type   op;
         mctrc_pkg::chan_stat_type stat;

         assign op.tick     = fire && (in_func_ff == mctrc_pkg::FUNC_TICK);
         assign op.load     = cmd_ok && (32'(in_channel_ff) == c);
         assign op.drive_on = drive_on;
         assign op.mask     = mask;

         mctrc_channel #(
            .TIMER_BITS (TIMER_BITS)
         ) u_channel (
            .clock (clock),
            .reset (reset),
            .op    (op),
            .dur   (dur),
            .stat  (stat)
         );

         assign relay_next[c*BE +: BE] = stat.bits_next;
         assign expired_next[c]        = stat.expired;
      end
   endgenerate

   // ---------------- result register ----------------
   logic              out_valid_ff;
   logic [CTRL_W-1:0] out_ctrl_ff;
   logic [EXP_W-1:0]  out_exp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ctrl_ff <= relay_next[CTRL_W-1:0];
         out_exp_ff  <= expired_next[EXP_W-1:0];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_exp_ff, out_ctrl_ff};

   // ---------------- checks ----------------
   // a command word never reports an expiry
   `MCTRC_ASSERT_NXT(a_cmd_no_expiry, clock, reset,
      fire && (in_func_ff == mctrc_pkg::FUNC_CMD), out_exp_ff == '0)
   // a new result only ever follows a word held in the input register
   `MCTRC_ASSERT_IMP(a_result_has_source, clock, reset,
      $rose(out_valid_ff), $past(in_valid_ff))
   // an empty result register never back-pressures the request side
   `MCTRC_ASSERT_IMP(a_ready_when_empty, clock, reset,
      !out_valid_ff, req_tready)

endmodule

/* rtl/core/mctrc_channel.sv */
// One relay channel: its three relay bits and its millisecond timer.
// Depends on mctrc_pkg.
module mctrc_channel #(
   parameter int TIMER_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mctrc_pkg::chan_op_type    op,
   input  logic [TIMER_BITS-1:0]     dur,
   output mctrc_pkg::chan_stat_type  stat
);

   logic                               active_ff, active_in;
   logic [TIMER_BITS-1:0]              left_ff, left_in;
   logic [mctrc_pkg::BITS_EACH-1:0]    bits_ff, bits_in;
   logic                               expired;

   always_comb begin
      active_in = active_ff;
      left_in   = left_ff;
      bits_in   = bits_ff;
      expired   = 1'b0;
      if (op.tick) begin
         if (active_ff) begin
            if (left_ff == '0) begin
               // expiring tick: drop bits and timer
               active_in = 1'b0;
               bits_in   = '0;
               expired   = 1'b1;
            end else begin
               left_in = left_ff - 1'b1;
            end
         end
      end else if (op.load) begin
         bits_in   = op.drive_on ? op.mask : '0;
         active_in = (dur != '0);
         left_in   = dur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         left_ff   <= '0;
         bits_ff   <= '0;
      end else begin
         active_ff <= active_in;
         left_ff   <= left_in;
         bits_ff   <= bits_in;
      end
   end

   assign stat.expired   = expired;
   assign stat.bits_next = bits_in;

endmodule

/* test/tb.sv */
// Self-checking testbench for the multi-channel timed relay controller.
// Depends on mctrc_pkg and the controller RTL; drives the req/rsp streams and
// the APB-style register port; checks every result word (predicted or typed in).
`timescale 1ns / 1ps

module tb;
   import mctrc_pkg::*;

   localparam int NCHAN      = 8;
   localparam int DIR_ROWS   = 24;
   localparam int PHASE_WORDS = 420;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int TIMEOUT_NS = 5_000_000;

   // codes outside the defined command and mode sets
   localparam logic [2:0] CMD_UNKNOWN  = 3'd7;
   localparam logic [1:0] MODE_UNKNOWN = 2'd3;

   typedef enum logic {ROW_WORD, ROW_CFG} row_kind_type;

   // one line of the directed table: either a request word or a register write
   typedef struct packed {
      row_kind_type kind;
      func_type    func;
      logic [2:0]  chan;
      logic [2:0]  cmd;
      logic [1:0]  mode;
      logic        known;     // expected result typed in below
      logic [23:0] ctrl;
      logic [7:0]  xmask;
      logic        reg_sel;
      logic [31:0] reg_val;
   } step_row_type;

   typedef struct {
      logic [23:0] ctrl;
      logic [7:0]  xmask;
   } relay_word_type;

   // DUT connections; every input starts at a known value
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr  = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   // predictor state: relay bits, channel timers and register copies
   logic [23:0] relays;
   logic        tmr_run  [NCHAN];
   logic [23:0] tmr_left [NCHAN];
   logic [23:0] hold_ms;
   logic [23:0] pulse_len;

   relay_word_type expected_words [$];
   relay_word_type seen_w;
   int          mismatches = 0;

   // idling and back-pressure control
   int          send_idle_pct = 12;
   int          recv_idle_pct = 85;
   bit          hold_req  = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_left = 0;

   // directed table: extremes, every command and mode, unknown codes,
   // zero durations, expiry on the tick after the count runs out, junk on ticks
   step_row_type dir_rows [DIR_ROWS] = '{
      // after reset nothing is driven
      '{ROW_WORD, FUNC_TICK, 3'd0, CMD_NONE, MODE_OFF, 1'b1, 24'h000000, 8'h00, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_CMD, 3'd3, CMD_NONE, MODE_ON, 1'b1, 24'h000000, 8'h00, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_CMD, 3'd5, CMD_UNKNOWN, MODE_PULSE, 1'b1, 24'h000000, 8'h00, 1'b0,
        32'd0},
      // top and bottom channel
      '{ROW_WORD, FUNC_CMD, 3'd7, CMD_ALL, MODE_ON, 1'b1, 24'hE00000, 8'h00, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_CMD, 3'd0, CMD_UP, MODE_PULSE, 1'b1, 24'hE00001, 8'h00, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_CMD, 3'd7, CMD_ALL, MODE_OFF, 1'b1, 24'h000001, 8'h00, 1'b0, 32'd0},
      // unknown mode behaves as off
      '{ROW_WORD, FUNC_CMD, 3'd1, CMD_STOP, MODE_UNKNOWN, 1'b1, 24'h000001, 8'h00, 1'b0,
        32'd0},
      '{ROW_WORD, FUNC_CMD, 3'd1, CMD_STOP, MODE_ON, 1'b1, 24'h000011, 8'h00, 1'b0, 32'd0},
      // zero hold time, two-tick pulse
      '{ROW_CFG, FUNC_CMD, 3'd0, CMD_NONE, MODE_OFF, 1'b0, 24'h0, 8'h0, REG_ON_HOLD, 32'd0},
      '{ROW_CFG, FUNC_CMD, 3'd0, CMD_NONE, MODE_OFF, 1'b0, 24'h0, 8'h0, REG_PULSE, 32'd2},
      '{ROW_WORD, FUNC_CMD, 3'd2, CMD_STOP_DOWN, MODE_ON, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_CMD, 3'd4, CMD_STOP_UP, MODE_PULSE, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_CMD, 3'd6, CMD_DOWN, MODE_PULSE, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_TICK, 3'd0, CMD_NONE, MODE_OFF, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_TICK, 3'd0, CMD_NONE, MODE_OFF, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0},
      // tick with every other field at its top value
      '{ROW_WORD, FUNC_TICK, 3'd7, CMD_UNKNOWN, MODE_UNKNOWN, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0},
      // widest hold time (upper data bits set too), zero pulse
      '{ROW_CFG, FUNC_CMD, 3'd0, CMD_NONE, MODE_OFF, 1'b0, 24'h0, 8'h0, REG_ON_HOLD,
        32'hFFFF_FFFF},
      '{ROW_CFG, FUNC_CMD, 3'd0, CMD_NONE, MODE_OFF, 1'b0, 24'h0, 8'h0, REG_PULSE, 32'd0},
      '{ROW_WORD, FUNC_CMD, 3'd3, CMD_ALL, MODE_ON, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_CMD, 3'd5, CMD_UP, MODE_PULSE, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_TICK, 3'd0, CMD_NONE, MODE_OFF, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_CMD, 3'd1, CMD_DOWN, MODE_ON, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_TICK, 3'd0, CMD_NONE, MODE_OFF, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0},
      '{ROW_WORD, FUNC_CMD, 3'd0, CMD_STOP_DOWN, MODE_OFF, 1'b0, 24'h0, 8'h0, 1'b0, 32'd0}
   };

   multi_channel_timed_relay_controller uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop in case a handshake never completes
   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%s", msg);
   endfunction

   // drop a channel's relay bits and its timer
   function automatic void clear_relay_channel(input int c);
      relays[c*BITS_EACH +: BITS_EACH] = '0;
      tmr_run[c]  = 1'b0;
      tmr_left[c] = '0;
   endfunction

   // advance the predicted relay state by one word and give the result
   function automatic void relay_predict(input logic func, input logic [2:0] ch,
                                         input logic [2:0] cmd, input logic [1:0] mode,
                                         output logic [23:0] ctrl, output logic [7:0] xmask);
      logic [BITS_EACH-1:0] sel;
      logic [23:0]          dur;
      logic                 drive;
      xmask = '0;
      sel   = '0;
      dur   = '0;
      drive = 1'b0;
      if (func == FUNC_TICK) begin
         // a timer at zero expires on this tick, otherwise it counts down
         for (int c = 0; c < NCHAN; c++) begin
            if (tmr_run[c]) begin
               if (tmr_left[c] == 0) begin
                  clear_relay_channel(c);
                  xmask[c] = 1'b1;
               end else begin
                  tmr_left[c] = tmr_left[c] - 1;
               end
            end
         end
      end else begin
         case (cmd)
            CMD_UP:        sel = UP_BIT;
            CMD_STOP:      sel = STOP_BIT;
            CMD_DOWN:      sel = DOWN_BIT;
            CMD_STOP_DOWN: sel = STOP_BIT | DOWN_BIT;
            CMD_STOP_UP:   sel = STOP_BIT | UP_BIT;
            CMD_ALL:       sel = UP_BIT | STOP_BIT | DOWN_BIT;
            default:       sel = '0;
         endcase
         case (mode)
            MODE_ON: begin
               drive = 1'b1;
               dur   = hold_ms;
            end
            MODE_PULSE: begin
               drive = 1'b1;
               dur   = pulse_len;
            end
            default: ;
         endcase
         // unknown commands leave everything as it is
         if (sel != '0) begin
            clear_relay_channel(ch);
            if (drive)
               relays[ch*BITS_EACH +: BITS_EACH] = sel;
            if (dur != '0) begin
               tmr_run[ch]  = 1'b1;
               tmr_left[ch] = dur;
            end
         end
      end
      ctrl = relays;
   endfunction

   // offer one request word, idling first at the sender's rate, and
   // queue its expected result once it is taken
   task automatic drive_word(input logic func, input logic [2:0] ch, input logic [2:0] cmd,
                             input logic [1:0] mode, input logic known,
                             input logic [23:0] k_ctrl, input logic [7:0] k_mask);
      relay_word_type w;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {mode, cmd, ch};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      relay_predict(func, ch, cmd, mode, w.ctrl, w.xmask);
      if (known) begin
         w.ctrl  = k_ctrl;
         w.xmask = k_mask;
      end
      expected_words.push_back(w);
   endtask

   // write a register once the block has drained, then read it back
   task automatic write_reg(input logic sel, input logic [31:0] val);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0)
         @(negedge clock);
      // let the two pipeline stages settle
      repeat (4) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (sel == REG_ON_HOLD)
         hold_ms = val[23:0];
      else
         pulse_len = val[23:0];
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata[23:0] !== val[23:0])
         note_mismatch($sformatf("register %0d readback: expected %06h, got %06h",
                                 sel, val[23:0], csr_prdata[23:0]));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // receiver: random idling, plus one long hold-off so the block backs up
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_OFF_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            note_mismatch($sformatf("result word %08h with nothing expected", rsp_tdata));
         end else begin
            seen_w = expected_words.pop_front();
            if (rsp_tdata[23:0] !== seen_w.ctrl || rsp_tdata[31:24] !== seen_w.xmask)
               note_mismatch($sformatf({"control word: expected %06h, got %06h; ",
                                        "expired mask: expected %02h, got %02h"},
                                       seen_w.ctrl, rsp_tdata[23:0],
                                       seen_w.xmask, rsp_tdata[31:24]));
         end
      end
   end

   initial begin
      logic       f;
      logic [2:0] ch;
      logic [2:0] cmd;
      logic [1:0] mode;
      int         r;

      // predictor starts from the reset state
      relays    = '0;
      hold_ms   = ON_HOLD_RESET;
      pulse_len = PULSE_RESET;
      for (int c = 0; c < NCHAN; c++) begin
         tmr_run[c]  = 1'b0;
         tmr_left[c] = '0;
      end

      // hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].kind == ROW_CFG)
            write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
         else
            drive_word(dir_rows[i].func, dir_rows[i].chan, dir_rows[i].cmd, dir_rows[i].mode,
                       dir_rows[i].known, dir_rows[i].ctrl, dir_rows[i].xmask);
      end

      // random phases: slow receiver, then slow sender, then full rate
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 12;
               recv_idle_pct = 85;
               write_reg(REG_ON_HOLD, $urandom_range(1, 12));
               write_reg(REG_PULSE, $urandom_range(0, 6));
            end
            1: begin
               send_idle_pct = 85;
               recv_idle_pct = 12;
               write_reg(REG_ON_HOLD, $urandom_range(0, 30));
               write_reg(REG_PULSE, $urandom_range(1, 3));
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               write_reg(REG_ON_HOLD, $urandom_range(2, 8));
               write_reg(REG_PULSE, 1);
            end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            r = $urandom_range(99);
            if (r < 45) begin
               // tick: the other fields carry junk
               f    = FUNC_TICK;
               ch   = $urandom_range(0, 7);
               cmd  = $urandom_range(0, 7);
               mode = $urandom_range(0, 3);
            end else begin
               f  = FUNC_CMD;
               ch = $urandom_range(0, 7);
               // mostly valid commands and modes, some unknown codes
               if ($urandom_range(99) < 90)
                  cmd = $urandom_range(1, 6);
               else
                  cmd = $urandom_range(0, 1) ? CMD_UNKNOWN : CMD_NONE;
               if ($urandom_range(99) < 92)
                  mode = $urandom_range(0, 2);
               else
                  mode = MODE_UNKNOWN;
            end
            drive_word(f, ch, cmd, mode, 1'b0, '0, '0);
            // at full rate, starve the result side for a long stretch
            if (p == 2 && n == 40)
               hold_req = 1'b1;
         end
      end

      // drain, then give the pipeline time to show any stray word
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
